// ----- rtl/bpc_pkg.sv -----
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int DEB_W   = 8;
    localparam int TIMER_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEB_W-1:0]   DEB_MAX   = '1;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_DELAY = 8'd3;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd5;
    localparam logic [TIMER_W-1:0] SHORT_RESET    = 16'd10;
    localparam logic [TIMER_W-1:0] LONG_RESET     = 16'd600;
    localparam logic [TIMER_W-1:0] PULSE_RESET    = 16'd600;

    typedef struct packed {
        logic button_level;
        logic reset_cv_edge;
    } t_in_item;

    typedef struct packed {
        logic short_press;
        logic long_release;
        logic long_press;
        logic repeat_pulse;
        logic reset_request;
    } t_out_item;

    typedef struct packed {
        logic rose;
        logic fell;
    } t_deb_evt;

    typedef struct packed {
        logic [TIMER_W-1:0] short_ticks;
        logic [TIMER_W-1:0] long_ticks;
        logic [TIMER_W-1:0] pulse_ticks;
    } t_press_cfg;

endpackage

// ----- rtl/bpc_debounce.sv -----
`timescale 1ns / 1ps

module bpc_debounce (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_raw,
    input  logic [bpc_pkg::DEB_W-1:0]  i_debounce_ticks,
    output bpc_pkg::t_deb_evt          o_evt
);
    import bpc_pkg::*;

    logic             r_level;
    logic             r_last_raw;
    logic [DEB_W-1:0] r_count;
    logic             n_level;
    logic             n_last_raw;
    logic [DEB_W-1:0] n_count;
    logic [DEB_W-1:0] count_inc;

    assign count_inc = (r_count == DEB_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_level    = r_level;
        n_last_raw = r_last_raw;
        n_count    = r_count;
        o_evt      = '0;
        if (i_raw != r_last_raw) begin
            n_last_raw = i_raw;
            n_count    = '0;
        end else begin
            n_count = count_inc;
            if (count_inc >= i_debounce_ticks && i_raw != r_level) begin
                n_level    = i_raw;
                n_count    = '0;
                o_evt.rose = i_raw;
                o_evt.fell = ~i_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= 1'b0;
            r_last_raw <= 1'b0;
            r_count    <= '0;
        end else if (i_advance) begin
            r_level    <= n_level;
            r_last_raw <= n_last_raw;
            r_count    <= n_count;
        end
    end

endmodule

// ----- rtl/bpc_press.sv -----
`timescale 1ns / 1ps

module bpc_press (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  bpc_pkg::t_deb_evt    i_evt,
    input  logic                 i_cv_edge,
    input  bpc_pkg::t_press_cfg  i_cfg,
    output bpc_pkg::t_out_item   o_result
);
    import bpc_pkg::*;

    logic [TIMER_W-1:0] r_timer;
    logic               r_held;
    logic [TIMER_W-1:0] n_timer;
    logic               n_held;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] over_long;

    assign timer_inc = (r_timer == TIMER_MAX) ? r_timer : r_timer + 1'b1;

    always_comb begin
        n_timer  = timer_inc;
        n_held   = r_held;
        o_result = '0;
        if (i_evt.rose) begin
            n_timer = '0;
            n_held  = 1'b1;
        end
        if (i_evt.fell) begin
            n_held = 1'b0;
            if (timer_inc >= i_cfg.short_ticks && timer_inc < i_cfg.long_ticks) begin
                o_result.short_press = 1'b1;
            end else if (timer_inc > i_cfg.long_ticks) begin
                o_result.long_release = 1'b1;
            end
            n_timer = '0;
        end
        over_long = n_timer - i_cfg.long_ticks;
        if (n_held && n_timer >= i_cfg.long_ticks) begin
            o_result.long_press = 1'b1;
            // each pulse rewinds the timer to the long threshold
            if (over_long >= i_cfg.pulse_ticks) begin
                o_result.repeat_pulse = 1'b1;
                n_timer = i_cfg.long_ticks;
            end
        end
        o_result.reset_request = i_cv_edge | o_result.short_press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_held  <= 1'b0;
        end else if (i_advance) begin
            r_timer <= n_timer;
            r_held  <= n_held;
        end
    end

endmodule

// ----- rtl/button_press_classifier_unit.sv -----
`timescale 1ns / 1ps

// debounced button with short, long and repeat press classification
// input channel: one word per millisecond tick carrying the raw button level
//   and a reset cv edge flag; output channel: one result word per input word
// config channel: register index and data, always ready; write only while idle
//   (0 debounce ticks, 1 short press ticks, 2 long press ticks, 3 pulse delay)
// path: an accepted word passes the input register, then the result register,
//   before it is offered on the output
// throughput: one word per cycle while results are taken; the debounce filter
//   and press timer update between the input and result registers
// reset: debounced level, raw history, stable count, timer and held flag clear,
//   registers return to 5, 10, 600, 600, both register stages empty
// stall: while the result word is not taken, the input register holds one more
//   word and then input ready drops; no word is lost or repeated
module button_press_classifier_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bpc_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output bpc_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bpc_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [DEB_W-1:0]   r_debounce_ticks;
    t_press_cfg         r_press_cfg;
    logic               advance;
    t_deb_evt           deb_evt;
    t_out_item          result;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    bpc_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_raw            (r_in.button_level),
        .i_debounce_ticks (r_debounce_ticks),
        .o_evt            (deb_evt)
    );

    bpc_press u_press (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_evt     (deb_evt),
        .i_cv_edge (r_in.reset_cv_edge),
        .i_cfg     (r_press_cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks        <= DEBOUNCE_RESET;
            r_press_cfg.short_ticks <= SHORT_RESET;
            r_press_cfg.long_ticks  <= LONG_RESET;
            r_press_cfg.pulse_ticks <= PULSE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE:    r_debounce_ticks        <= i_cfg_data[DEB_W-1:0];
                REG_SHORT_PRESS: r_press_cfg.short_ticks <= i_cfg_data[TIMER_W-1:0];
                REG_LONG_PRESS:  r_press_cfg.long_ticks  <= i_cfg_data[TIMER_W-1:0];
                REG_PULSE_DELAY: r_press_cfg.pulse_ticks <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- sim/press_event_checker.sv -----
`timescale 1ns / 1ps

module press_event_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  bpc_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  bpc_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bpc_pkg::*;

    logic [DEB_W-1:0]   debounce_ticks;
    logic [TIMER_W-1:0] short_ticks;
    logic [TIMER_W-1:0] long_ticks;
    logic [TIMER_W-1:0] pulse_ticks;

    logic               deb_level;
    logic               last_raw;
    logic [DEB_W-1:0]   stable_cnt;
    logic [TIMER_W-1:0] hold_timer;
    logic               held;

    t_out_item          expected_events[$];
    int                 word_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one tick of the debounce filter and the press classification
    function automatic t_out_item classify_tick(t_in_item w);
        t_out_item r;
        logic      rose;
        logic      fell;
        r    = '0;
        rose = 1'b0;
        fell = 1'b0;
        if (hold_timer != TIMER_MAX) begin
            hold_timer = hold_timer + 1'b1;
        end
        if (w.button_level != last_raw) begin
            last_raw   = w.button_level;
            stable_cnt = '0;
        end else begin
            if (stable_cnt != DEB_MAX) begin
                stable_cnt = stable_cnt + 1'b1;
            end
            if (stable_cnt >= debounce_ticks && w.button_level != deb_level) begin
                deb_level  = w.button_level;
                stable_cnt = '0;
                rose       = w.button_level;
                fell       = !w.button_level;
            end
        end
        if (rose) begin
            hold_timer = '0;
            held       = 1'b1;
        end
        if (fell) begin
            held = 1'b0;
            if (hold_timer >= short_ticks && hold_timer < long_ticks) begin
                r.short_press = 1'b1;
            end else if (hold_timer > long_ticks) begin
                r.long_release = 1'b1;
            end
            hold_timer = '0;
        end
        if (held && hold_timer >= long_ticks) begin
            r.long_press = 1'b1;
            // each repeat pulse rewinds the timer to the long threshold
            if (hold_timer - long_ticks >= pulse_ticks) begin
                r.repeat_pulse = 1'b1;
                hold_timer     = long_ticks;
            end
        end
        r.reset_request = w.reset_cv_edge | r.short_press;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%s", msg);
        o_fail_count++;
    endtask

    task automatic check_field(string field, logic got, logic want);
        if (got !== want) begin
            report_mismatch($sformatf("result word %0d: %s is %0b, expected %0b",
                                      word_idx, field, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            debounce_ticks = DEBOUNCE_RESET;
            short_ticks    = SHORT_RESET;
            long_ticks     = LONG_RESET;
            pulse_ticks    = PULSE_RESET;
            deb_level      = 1'b0;
            last_raw       = 1'b0;
            stable_cnt     = '0;
            hold_timer     = '0;
            held           = 1'b0;
            word_idx       = 0;
            expected_events.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("result word %0d: nothing pending", word_idx));
                end else begin
                    want = expected_events.pop_front();
                    check_field("short_press", i_out_data.short_press, want.short_press);
                    check_field("long_release", i_out_data.long_release, want.long_release);
                    check_field("long_press", i_out_data.long_press, want.long_press);
                    check_field("repeat_pulse", i_out_data.repeat_pulse, want.repeat_pulse);
                    check_field("reset_request", i_out_data.reset_request,
                                want.reset_request);
                end
                word_idx++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: begin
                        debounce_ticks = i_cfg_data[DEB_W-1:0];
                    end
                    REG_SHORT_PRESS: begin
                        short_ticks = i_cfg_data;
                    end
                    REG_LONG_PRESS: begin
                        long_ticks = i_cfg_data;
                    end
                    REG_PULSE_DELAY: begin
                        pulse_ticks = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_events.push_back(classify_tick(i_in_data));
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// ----- sim/button_press_classifier_unit_tb.sv -----
`timescale 1ns / 1ps

module button_press_classifier_unit_tb;
    import bpc_pkg::*;

    // index that maps to no register, all bits set
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

    typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN, RX_HOLD} t_rx_mode;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    // thresholds in use, only to shape the press lengths
    int deb_cfg   = int'(DEBOUNCE_RESET);
    int short_cfg = int'(SHORT_RESET);
    int long_cfg  = int'(LONG_RESET);
    int pulse_cfg = int'(PULSE_RESET);

    int ticks_sent = 0;
    int burst_left = 0;

    button_press_classifier_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    press_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #40ms;
        $display("button_press_classifier_unit verification failed");
        $finish;
    end

    // receiver: stretches of always ready, sparse stalls, coin flips and hard stalls
    initial begin
        t_rx_mode mode;
        int       span;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = (mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(16, 300);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    RX_OPEN: begin
                        out_ready <= 1'b1;
                    end
                    RX_SPARSE: begin
                        out_ready <= ($urandom_range(0, 3) != 0);
                    end
                    RX_COIN: begin
                        out_ready <= ($urandom_range(0, 1) != 0);
                    end
                    default: begin
                        out_ready <= 1'b0;
                    end
                endcase
            end
        end
    end

    function automatic logic rand_cv();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_tick(logic level, logic cv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= '{button_level: level, reset_cv_edge: cv};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic drive_level(logic level, int n);
        repeat (n) send_tick(level, rand_cv());
    endtask

    task automatic chatter(int n);
        repeat (n) send_tick($urandom_range(0, 1) != 0, rand_cv());
    endtask

    task automatic press_episode(int hold, int rest);
        chatter($urandom_range(0, 3));
        drive_level(1'b1, hold);
        chatter($urandom_range(0, 3));
        drive_level(1'b0, rest);
    endtask

    // exact hold with no chatter and no cv, released long enough to register
    task automatic directed_press(int hold);
        repeat (hold) send_tick(1'b1, 1'b0);
        repeat (deb_cfg + 2) send_tick(1'b0, 1'b0);
    endtask

    task automatic run_episodes(int budget);
        int stop_at;
        int hold;
        int rest;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                chatter($urandom_range(1, 8));
            end else begin
                // a clean n-tick hold, no repeat, leaves the timer at n on release
                case ($urandom_range(0, 3))
                    0: hold = $urandom_range(1, deb_cfg + short_cfg + 3);
                    1: hold = long_cfg - 1 + $urandom_range(0, 2);
                    2: hold = long_cfg + $urandom_range(1, 2 * pulse_cfg + 4);
                    default: hold = $urandom_range(1, deb_cfg + 1);
                endcase
                if (hold < 1) begin
                    hold = 1;
                end
                rest = deb_cfg + $urandom_range(1, 4);
                if ($urandom_range(0, 3) == 0) begin
                    rest += $urandom_range(0, deb_cfg);
                end
                press_episode(hold, rest);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(int deb, int short_t, int long_t, int pulse);
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(REG_SHORT_PRESS, CFG_DATA_W'(short_t));
        write_reg(REG_LONG_PRESS, CFG_DATA_W'(long_t));
        write_reg(REG_PULSE_DELAY, CFG_DATA_W'(pulse));
        deb_cfg   = deb;
        short_cfg = short_t;
        long_cfg  = long_t;
        pulse_cfg = pulse;
    endtask

    // drain the block so registers can be written
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset thresholds
        run_episodes(600);
        settle();

        set_config(1, 2, 5, 2);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        directed_press(2);   // shortest short press
        directed_press(5);   // release right at the long threshold
        directed_press(9);   // one repeat pulse, then long release
        run_episodes(100);
        settle();

        // zero debounce, zero short threshold, zero pulse delay
        set_config(0, 0, 3, 0);
        run_episodes(150);
        settle();

        // longest debounce, short threshold above long
        set_config(int'(DEB_MAX), 40, 20, 7);
        run_episodes(300);
        settle();

        set_config(3, 6, 30, 5);
        run_episodes(200);
        settle();

        // unmapped write must not land
        set_config(2, 4, 12, 3);
        write_reg(REG_UNMAPPED, '0);
        run_episodes(100);
        settle();

        set_config(1, 1, 1, 1);
        run_episodes(150);
        settle();

        if (fail_count == 0) begin
            $display("button_press_classifier_unit verification clean");
        end else begin
            $display("button_press_classifier_unit verification failed");
        end
        $finish;
    end

endmodule
